>>> rtl/lkvc_pkg.sv
// Shared constants for the LRU key/value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W = 5;
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

endpackage

>>> rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
`timescale 1ns / 1ps

// An item is taken on every clock edge where start is high and busy is low, so a new get or
// set may be issued in every cycle; busy is high only during reset. A get produces one result
// beat on hit and read_value, marked by done, from the input register through the result
// register; a set produces no beat. The beat cannot be held off. The parallel key compare and
// the recency update lie in combinational logic between those two registers, so each item sees
// every earlier item already applied. Nothing needs clearing after reset. The capacity register
// at byte address 0 takes values 1 to ENTRIES; zero acts as one and larger values as ENTRIES.
// Lowering it never drops entries at once.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation,
  input  logic signed [lkvc_pkg::DATA_W-1:0]    key,
  input  logic signed [lkvc_pkg::DATA_W-1:0]    value,
  output logic                                  done,
  output logic                                  hit,
  output logic signed [lkvc_pkg::DATA_W-1:0]    read_value,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0]  capacity;

  logic                        item_valid;
  logic                        item_op;
  logic [lkvc_pkg::DATA_W-1:0] item_key;
  logic [lkvc_pkg::DATA_W-1:0] item_value;

  logic [lkvc_pkg::DATA_W-1:0] keys [ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] values [ENTRIES];
  logic [ENTRIES-1:0]          valid;
  logic [RW-1:0]               rank [ENTRIES];
  logic [CW-1:0]               count;

  logic [ENTRIES-1:0]          match;
  logic                        hit_any;
  logic [IW-1:0]               hit_slot;
  logic [IW-1:0]               free_slot;
  logic [IW-1:0]               victim_slot;
  logic [IW-1:0]               target;
  logic [CW-1:0]               ref_rank;
  logic [MW-1:0]               eff_cap;
  logic                        full;
  logic                        touch_en;
  logic                        insert_new;
  logic                        value_we;

  logic [ENTRIES-1:0]          valid_next;
  logic [RW-1:0]               rank_next [ENTRIES];
  logic [CW-1:0]               count_next;

  logic                        done_q;
  logic                        hit_q;
  logic [lkvc_pkg::DATA_W-1:0] rd_data;

  assign busy   = rst;
  assign pready = 1'b1;
  assign prdata = (paddr == lkvc_pkg::ADDR_CAPACITY) ?
                  lkvc_pkg::APB_DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == lkvc_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_op    <= operation;
      item_key   <= key;
      item_value <= value;
    end
  end

  always_comb begin
    match       = '0;
    hit_slot    = '0;
    free_slot   = '0;
    victim_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (keys[i] == item_key);
      if (match[i]) begin
        hit_slot = IW'(i);
      end
      if (!valid[i]) begin
        free_slot = IW'(i);
      end
      if (valid[i] && CW'(rank[i]) == CW'(count - CW'(1))) begin
        victim_slot = IW'(i);
      end
    end
    hit_any = |match;

    if (capacity == '0) begin
      eff_cap = MW'(1);
    end else if (MW'(capacity) > MW'(ENTRIES)) begin
      eff_cap = MW'(ENTRIES);
    end else begin
      eff_cap = MW'(capacity);
    end
    full = MW'(count) >= eff_cap;

    touch_en   = item_valid && (hit_any || item_op == lkvc_pkg::OP_SET);
    insert_new = item_valid && item_op == lkvc_pkg::OP_SET && !hit_any && !full;
    value_we   = item_valid && item_op == lkvc_pkg::OP_SET;

    priority if (hit_any) begin
      target   = hit_slot;
      ref_rank = CW'(rank[hit_slot]);
    end else if (full) begin
      target   = victim_slot;
      ref_rank = CW'(count - CW'(1));
    end else begin
      target   = free_slot;
      ref_rank = count;
    end

    valid_next = valid;
    count_next = insert_new ? CW'(count + CW'(1)) : count;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (touch_en) begin
        if (IW'(i) == target) begin
          rank_next[i] = '0;
          valid_next[i] = 1'b1;
        end else if (valid[i] && CW'(rank[i]) < ref_rank) begin
          rank_next[i] = RW'(rank[i] + RW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_op == lkvc_pkg::OP_SET && !hit_any) begin
      keys[target] <= item_key;
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      values[target] <= item_value;
    end
    rd_data <= values[hit_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= item_valid && item_op == lkvc_pkg::OP_GET;
    end
  end

  always_ff @(posedge clk) begin
    hit_q <= hit_any;
  end

  assign done       = done_q;
  assign hit        = hit_q;
  assign read_value = hit_q ? rd_data : lkvc_pkg::MISS_VALUE;

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    ($countones(valid) == int'(count)) && (int'(count) <= ENTRIES))
    else $error("fill count disagrees with the valid entries");

  a_keys_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one valid entry holds the same key");

  a_get_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == lkvc_pkg::OP_GET) |-> ##2 done)
    else $error("get did not produce a result beat");

  a_set_gives_none: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == lkvc_pkg::OP_SET) |-> ##2 !done)
    else $error("set produced a result beat");

endmodule

>>> bench/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key/value cache: directed table, then random phases.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  localparam int ENTRIES = 16;
  localparam int POOL_SIZE = 24;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [lkvc_pkg::CAP_W-1:0]  cap;
    logic                        op;
    logic [lkvc_pkg::DATA_W-1:0] k;
    logic [lkvc_pkg::DATA_W-1:0] v;
    logic                        typed;
    logic                        want_hit;
    logic [lkvc_pkg::DATA_W-1:0] want_value;
  } stim_row_t;

  typedef struct packed {
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] value;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = lkvc_pkg::OP_GET;
  logic signed [lkvc_pkg::DATA_W-1:0] key = '0;
  logic signed [lkvc_pkg::DATA_W-1:0] value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lkvc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lkvc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic busy;
  logic done;
  logic hit;
  logic signed [lkvc_pkg::DATA_W-1:0] read_value;
  logic [lkvc_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  logic pin_typed = 1'b0;
  logic pin_hit = 1'b0;
  logic [lkvc_pkg::DATA_W-1:0] pin_value = '0;

  logic [lkvc_pkg::DATA_W-1:0] model_key [ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] model_val [ENTRIES];
  logic                        model_valid [ENTRIES];
  logic [3:0]                  model_rank [ENTRIES];
  logic [lkvc_pkg::CAP_W-1:0]  model_capacity = lkvc_pkg::CAPACITY_RESET;

  answer_t pending_reads[$];
  logic [lkvc_pkg::DATA_W-1:0] key_pool [POOL_SIZE];
  int error_count = 0;
  int cycle_count = 0;

  stim_row_t directed_rows [26];

  lru_key_value_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .key(key), .value(value),
    .done(done), .hit(hit), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      model_key[i] = '0;
      model_val[i] = '0;
      model_valid[i] = 1'b0;
      model_rank[i] = '0;
    end
  end

  task automatic report_mismatch(input string what,
                                 input logic [lkvc_pkg::DATA_W-1:0] got,
                                 input logic [lkvc_pkg::DATA_W-1:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int effective_capacity();
    if (model_capacity == 0) return 1;
    if (model_capacity > ENTRIES) return ENTRIES;
    return int'(model_capacity);
  endfunction

  function automatic void promote(input int s);
    logic [3:0] r;
    r = model_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (model_valid[i] && i != s && model_rank[i] < r) model_rank[i]++;
    model_rank[s] = '0;
  endfunction

  function automatic void cache_access(input logic op,
                                       input logic [lkvc_pkg::DATA_W-1:0] k,
                                       input logic [lkvc_pkg::DATA_W-1:0] v,
                                       output logic answers,
                                       output answer_t ans);
    int s;
    int cnt;
    int victim;
    logic [3:0] top;
    s = -1;
    cnt = 0;
    victim = -1;
    top = '0;
    ans = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (model_valid[i] && model_key[i] == k && s < 0) s = i;
      if (model_valid[i]) cnt++;
    end
    answers = (op == lkvc_pkg::OP_GET);
    if (op == lkvc_pkg::OP_SET) begin
      if (s >= 0) begin
        model_val[s] = v;
        promote(s);
      end else if (cnt >= effective_capacity()) begin
        for (int i = 0; i < ENTRIES; i++)
          if (model_valid[i] && (victim < 0 || model_rank[i] > top)) begin
            victim = i;
            top = model_rank[i];
          end
        model_key[victim] = k;
        model_val[victim] = v;
        promote(victim);
      end else begin
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!model_valid[i]) victim = i;
        for (int i = 0; i < ENTRIES; i++)
          if (model_valid[i]) model_rank[i]++;
        model_valid[victim] = 1'b1;
        model_key[victim] = k;
        model_val[victim] = v;
        model_rank[victim] = '0;
      end
    end else if (s >= 0) begin
      promote(s);
      ans.hit = 1'b1;
      ans.value = model_val[s];
    end else begin
      ans.hit = 1'b0;
      ans.value = lkvc_pkg::MISS_VALUE;
    end
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t predicted;
    logic answers;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("lru_key_value_cache test failed");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("result beat with nothing expected", read_value, '0);
        end else begin
          want = pending_reads.pop_front();
          if (hit !== want.hit) report_mismatch("hit", {31'b0, hit}, {31'b0, want.hit});
          if (read_value !== want.value) report_mismatch("read_value", read_value, want.value);
        end
      end
      if (start && !busy) begin
        cache_access(operation, key, value, answers, predicted);
        if (answers) begin
          if (pin_typed) pending_reads.push_back(answer_t'{hit: pin_hit, value: pin_value});
          else pending_reads.push_back(predicted);
        end
      end
    end
  end

  task automatic send_request(input logic op, input logic [lkvc_pkg::DATA_W-1:0] k,
                              input logic [lkvc_pkg::DATA_W-1:0] v, input logic typed,
                              input logic want_hit,
                              input logic [lkvc_pkg::DATA_W-1:0] want_value,
                              input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    key <= k;
    value <= v;
    pin_typed <= typed;
    pin_hit <= want_hit;
    pin_value <= want_value;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lkvc_pkg::ADDR_CAPACITY;
    pwdata <= {{(lkvc_pkg::APB_DATA_W - lkvc_pkg::CAP_W){1'b0}}, cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_capacity = cap;
  endtask

  function automatic logic [lkvc_pkg::DATA_W-1:0] edge_word();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  initial begin
    logic [lkvc_pkg::CAP_W-1:0] phase_cap [PHASES];
    int phase_idle [PHASES];
    int pool_used;
    int waited;
    logic op;
    logic [lkvc_pkg::DATA_W-1:0] k;
    logic [lkvc_pkg::DATA_W-1:0] v;

    directed_rows = '{
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0,
        1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0,
        1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0005, 32'hDEAD_BEEF,
        1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{ROW_CFG, 5'd2, lkvc_pkg::OP_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h0000_0001, 32'h0000_0011, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h0000_0002, 32'h0000_0022, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CFG, 5'd0, lkvc_pkg::OP_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h0000_0003, 32'h0000_0033, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0003, 32'h0, 1'b1, 1'b1, 32'h0000_0033},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0002, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CFG, 5'd31, lkvc_pkg::OP_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_SET, 32'h0000_0004, 32'h0000_0044, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0004, 32'h0, 1'b1, 1'b1, 32'h0000_0044},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'h0000_0003, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 5'd0, lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0}
    };

    phase_cap = '{5'd1, 5'd16, 5'd0, 5'd31, 5'(
      $urandom_range(0, 31)), 5'($urandom_range(1, 16)), 5'd2, 5'($urandom_range(0, 31))};
    phase_idle = '{0, 75, 0, 34, 75, 34, 0, 34};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_capacity(directed_rows[i].cap);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].v,
                     directed_rows[i].typed, directed_rows[i].want_hit,
                     directed_rows[i].want_value, 0);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      pool_used = $urandom_range(1, POOL_SIZE);
      foreach (key_pool[i]) key_pool[i] = ($urandom_range(0, 9) == 0) ? edge_word() : $urandom();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op = ($urandom_range(0, 99) < 45) ? lkvc_pkg::OP_SET : lkvc_pkg::OP_GET;
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_used - 1)] : $urandom();
        v = ($urandom_range(0, 9) == 0) ? edge_word() : $urandom();
        send_request(op, k, v, 1'b0, 1'b0, '0, phase_idle[p]);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending_reads.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_reads.size() != 0)
      report_mismatch("results never arrived", pending_reads.size(), '0);
    if (error_count == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
